/* rtl/assert_macros.svh */
// Shared assertion macros for the session table checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define STA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define STA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sta_pkg.sv */
package sta_pkg;

    // Action codes
    localparam logic [1:0] ACT_PUT     = 2'd0;
    localparam logic [1:0] ACT_REMOVE  = 2'd1;
    localparam logic [1:0] ACT_REFRESH = 2'd2;
    localparam logic [1:0] ACT_SWEEP   = 2'd3;

    // Field widths
    localparam int ACCT_W  = 32;
    localparam int SID_W   = 64;
    localparam int TIME_W  = 64;
    localparam int GRACE_W = 32;
    localparam int COUNT_W = 7;

    // Register port
    localparam int              APB_ADDR_W  = 3;
    localparam int              APB_DATA_W  = 32;
    localparam logic [0:0]      REG_GRACE   = 1'b0;
    localparam logic [31:0]     GRACE_RESET = 32'd30000;

    // One stored table entry
    typedef struct packed {
        logic              valid;
        logic [ACCT_W-1:0] account;
        logic [SID_W-1:0]  session;
        logic [TIME_W-1:0] last_refresh;
    } entry_t;

    // Compare results for one entry
    typedef struct packed {
        logic acct_hit;
        logic sid_hit;
        logic free;
        logic expired;
    } cmp_flags_t;

endpackage

/* rtl/sta_ram.sv */
module sta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/sta_cmp_unit.sv */
module sta_cmp_unit (
    input  sta_pkg::entry_t                    entry,
    input  logic [sta_pkg::ACCT_W-1:0]         account_id,
    input  logic [sta_pkg::SID_W-1:0]          session_id,
    input  logic [sta_pkg::TIME_W-1:0]         now_ms,
    input  logic [sta_pkg::GRACE_W-1:0]        grace_ms,
    output sta_pkg::cmp_flags_t                flags
);

    logic [sta_pkg::TIME_W:0] deadline;

    // Entry expires when now exceeds last refresh plus grace (no wrap, one bit wider)
    assign deadline = {1'b0, entry.last_refresh}
                    + {{(sta_pkg::TIME_W + 1 - sta_pkg::GRACE_W){1'b0}}, grace_ms};

    always_comb
    begin
        flags.acct_hit = entry.valid && (entry.account == account_id);
        flags.sid_hit  = (entry.session == session_id);
        flags.free     = !entry.valid;
        flags.expired  = entry.valid && ({1'b0, now_ms} > deadline);
    end

endmodule

/* rtl/session_table_with_aging.sv */
// Flow: a taken start runs a scan of every table entry and then a finish step, after
// which done pulses. A new start is taken only once the block is back at idle, and
// each one reads every table entry once through the entry memory's single read port.
// Reset: valid marks are cleared by a pass of TABLE_ENTRIES cycles after reset,
// with busy high; grace_ms resets to 30000. Results cannot be stalled.
module session_table_with_aging #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         action,
    input  logic [sta_pkg::ACCT_W-1:0]         account_id,
    input  logic [sta_pkg::SID_W-1:0]          session_id,
    input  logic [sta_pkg::TIME_W-1:0]         now_ms,
    output logic                               done,
    output logic                               was_present,
    output logic                               removed,
    output logic                               table_full,
    output logic [sta_pkg::COUNT_W-1:0]        swept_count,
    output logic [sta_pkg::COUNT_W-1:0]        live_count,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sta_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sta_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sta_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int ENT_W = $bits(sta_pkg::entry_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] NUM_ENT  = CNT_W'(TABLE_ENTRIES);

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             addr_reg, addr_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]             rd_idx_reg, rd_idx_next;
    logic                         hit_reg, hit_next;
    logic [IDX_W-1:0]             hit_idx_reg, hit_idx_next;
    logic                         free_found_reg, free_found_next;
    logic [IDX_W-1:0]             free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]             live_reg, live_next;
    logic [CNT_W-1:0]             swept_reg, swept_next;
    logic [sta_pkg::GRACE_W-1:0]  grace_reg, grace_next;

    logic                         done_reg, done_next;
    logic                         was_present_reg, was_present_next;
    logic                         removed_reg, removed_next;
    logic                         full_reg, full_next;
    logic [sta_pkg::COUNT_W-1:0]  swept_out_reg, swept_out_next;
    logic [sta_pkg::COUNT_W-1:0]  live_out_reg, live_out_next;

    logic [1:0]                   act_reg;
    logic [sta_pkg::ACCT_W-1:0]   acct_reg;
    logic [sta_pkg::SID_W-1:0]    sid_reg;
    logic [sta_pkg::TIME_W-1:0]   now_reg;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    sta_pkg::entry_t              ram_wdata;
    logic                         ram_re;
    logic [IDX_W-1:0]             ram_raddr;
    logic [ENT_W-1:0]             ram_rdata;
    sta_pkg::entry_t              rd_entry;
    sta_pkg::cmp_flags_t          flags;

    logic                         accept;
    logic                         cfg_write;
    logic [CNT_W+sta_pkg::COUNT_W-1:0] live_wide;
    logic [CNT_W+sta_pkg::COUNT_W-1:0] swept_wide;

    assign accept    = start && (state_reg == ST_IDLE);
    assign cfg_write = psel && penable && pwrite
                    && (paddr[sta_pkg::APB_ADDR_W-1:2] == sta_pkg::REG_GRACE);
    assign rd_entry  = sta_pkg::entry_t'(ram_rdata);

    // Entry memory
    sta_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ENT_W'(ram_wdata)),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared compare unit on the entry just read
    sta_cmp_unit u_cmp (
        .entry      (rd_entry),
        .account_id (acct_reg),
        .session_id (sid_reg),
        .now_ms     (now_reg),
        .grace_ms   (grace_reg),
        .flags      (flags)
    );

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        addr_next        = addr_reg;
        rd_pend_next     = 1'b0;
        rd_idx_next      = rd_idx_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        live_next        = live_reg;
        swept_next       = swept_reg;
        done_next        = 1'b0;
        was_present_next = was_present_reg;
        removed_next     = removed_reg;
        full_next        = full_reg;
        swept_out_next   = swept_out_reg;
        live_out_next    = live_out_reg;
        ram_we           = 1'b0;
        ram_waddr        = addr_reg[IDX_W-1:0];
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = addr_reg[IDX_W-1:0];
        live_wide        = '0;
        swept_wide       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Drop the valid mark of one entry per cycle
                ram_we    = 1'b1;
                ram_waddr = addr_reg[IDX_W-1:0];
                addr_next = addr_reg + CNT_W'(1);
                if (addr_reg[IDX_W-1:0] == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next      = ST_SCAN;
                    addr_next       = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    swept_next      = '0;
                end
            end

            ST_SCAN:
            begin
                // Issue the next read
                if (addr_reg < NUM_ENT)
                begin
                    ram_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = addr_reg[IDX_W-1:0];
                    addr_next    = addr_reg + CNT_W'(1);
                end
                // Evaluate the entry returned from the previous read
                if (rd_pend_reg)
                begin
                    if (act_reg == sta_pkg::ACT_SWEEP)
                    begin
                        if (flags.expired)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = rd_idx_reg;
                            live_next  = live_reg - CNT_W'(1);
                            swept_next = swept_reg + CNT_W'(1);
                        end
                    end
                    else if (act_reg == sta_pkg::ACT_REMOVE)
                    begin
                        if (flags.acct_hit && flags.sid_hit)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = rd_idx_reg;
                        end
                    end
                    else
                    begin
                        if (flags.acct_hit)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = rd_idx_reg;
                        end
                        if (flags.free && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = rd_idx_reg;
                        end
                    end
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                was_present_next = 1'b0;
                removed_next     = 1'b0;
                full_next        = 1'b0;
                if (act_reg == sta_pkg::ACT_SWEEP)
                begin
                    // Sweep already wrote its entries
                end
                else if (act_reg == sta_pkg::ACT_REMOVE)
                begin
                    if (hit_reg)
                    begin
                        ram_we       = 1'b1;
                        ram_waddr    = hit_idx_reg;
                        live_next    = live_reg - CNT_W'(1);
                        removed_next = 1'b1;
                    end
                end
                else
                begin
                    ram_wdata.valid        = 1'b1;
                    ram_wdata.account      = acct_reg;
                    ram_wdata.session      = sid_reg;
                    ram_wdata.last_refresh = now_reg;
                    if (hit_reg)
                    begin
                        ram_we           = 1'b1;
                        ram_waddr        = hit_idx_reg;
                        was_present_next = 1'b1;
                    end
                    else if (free_found_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = free_idx_reg;
                        live_next = live_reg + CNT_W'(1);
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
                live_wide      = {{sta_pkg::COUNT_W{1'b0}}, live_next};
                swept_wide     = {{sta_pkg::COUNT_W{1'b0}}, swept_reg};
                live_out_next  = live_wide[sta_pkg::COUNT_W-1:0];
                swept_out_next = swept_wide[sta_pkg::COUNT_W-1:0];
                done_next      = 1'b1;
                state_next     = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Register write
    always_comb
    begin
        grace_next = grace_reg;
        if (cfg_write)
        begin
            grace_next = pwdata;
        end
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            addr_reg        <= '0;
            rd_pend_reg     <= 1'b0;
            hit_reg         <= 1'b0;
            free_found_reg  <= 1'b0;
            live_reg        <= '0;
            swept_reg       <= '0;
            grace_reg       <= sta_pkg::GRACE_RESET;
            done_reg        <= 1'b0;
            was_present_reg <= 1'b0;
            removed_reg     <= 1'b0;
            full_reg        <= 1'b0;
            swept_out_reg   <= '0;
            live_out_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            addr_reg        <= addr_next;
            rd_pend_reg     <= rd_pend_next;
            hit_reg         <= hit_next;
            free_found_reg  <= free_found_next;
            live_reg        <= live_next;
            swept_reg       <= swept_next;
            grace_reg       <= grace_next;
            done_reg        <= done_next;
            was_present_reg <= was_present_next;
            removed_reg     <= removed_next;
            full_reg        <= full_next;
            swept_out_reg   <= swept_out_next;
            live_out_reg    <= live_out_next;
        end
    end

    // Hold the transaction fields and entry indexes
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        if (accept)
        begin
            act_reg  <= action;
            acct_reg <= account_id;
            sid_reg  <= session_id;
            now_reg  <= now_ms;
        end
    end

    // Ports
    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign was_present = was_present_reg;
    assign removed     = removed_reg;
    assign table_full  = full_reg;
    assign swept_count = swept_out_reg;
    assign live_count  = live_out_reg;
    assign pready      = 1'b1;
    assign prdata      = (paddr[sta_pkg::APB_ADDR_W-1:2] == sta_pkg::REG_GRACE)
                       ? grace_reg : '0;

endmodule

/* rtl/sta_checker.sv */
`include "assert_macros.svh"

module sta_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        was_present,
    input logic                        removed,
    input logic                        table_full,
    input logic [sta_pkg::COUNT_W-1:0] live_count
);

    // A taken transaction keeps the block busy until its result
    `STA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy not raised after start")

    // Results arrive only once the sequencer is back at rest
    `STA_ASSERT_IMP(a_done_idle, done, !busy, "result strobed while busy")

    // A result is a single-cycle pulse
    `STA_ASSERT_NXT(a_done_pulse, done, !done, "result strobe held for two cycles")

    // At most one outcome flag per result
    `STA_ASSERT_IMP(a_flags_excl, done, $onehot0({was_present, removed, table_full}), "flag clash")

    // Live count moves only with a result
    `STA_ASSERT_IMP(a_live_hold, !done, $stable(live_count), "live count moved without a result")

endmodule

bind session_table_with_aging sta_checker u_sta_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .was_present (was_present),
    .removed     (removed),
    .table_full  (table_full),
    .live_count  (live_count)
);

/* test/tb_session_table_with_aging.sv */
module tb_session_table_with_aging;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = 64;
    localparam int POOL_SIZE     = 72;
    localparam int PHASE_ITEMS   = 88;

    typedef struct packed {
        logic                        was_present;
        logic                        removed;
        logic                        table_full;
        logic [sta_pkg::COUNT_W-1:0] swept_count;
        logic [sta_pkg::COUNT_W-1:0] live_count;
    } outcome_t;

    typedef struct {
        logic [1:0]                 action;
        logic [sta_pkg::ACCT_W-1:0] account;
        logic [sta_pkg::SID_W-1:0]  session;
        logic [sta_pkg::TIME_W-1:0] stamp;
        bit                         typed;
        outcome_t                   want;
    } stim_row_t;

    // Block ports
    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           start      = 1'b0;
    logic [1:0]                     action     = sta_pkg::ACT_PUT;
    logic [sta_pkg::ACCT_W-1:0]     account_id = '0;
    logic [sta_pkg::SID_W-1:0]      session_id = '0;
    logic [sta_pkg::TIME_W-1:0]     now_ms     = '0;
    logic                           psel       = 1'b0;
    logic                           penable    = 1'b0;
    logic                           pwrite     = 1'b0;
    logic [sta_pkg::APB_ADDR_W-1:0] paddr      = '0;
    logic [sta_pkg::APB_DATA_W-1:0] pwdata     = '0;
    logic                           busy;
    logic                           done;
    logic                           was_present;
    logic                           removed;
    logic                           table_full;
    logic [sta_pkg::COUNT_W-1:0]    swept_count;
    logic [sta_pkg::COUNT_W-1:0]    live_count;
    logic [sta_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // Shadow copy of the session table
    logic                           tbl_valid   [TABLE_ENTRIES];
    logic [sta_pkg::ACCT_W-1:0]     tbl_account [TABLE_ENTRIES];
    logic [sta_pkg::SID_W-1:0]      tbl_session [TABLE_ENTRIES];
    logic [sta_pkg::TIME_W-1:0]     tbl_stamp   [TABLE_ENTRIES];
    int                             live_total;
    logic [sta_pkg::GRACE_W-1:0]    grace_cfg;

    outcome_t                       pending_outcomes [$];
    stim_row_t                      directed_rows [$];
    logic [sta_pkg::ACCT_W-1:0]     acct_pool [POOL_SIZE];
    logic [sta_pkg::TIME_W-1:0]     clock_ms;
    bit                             no_gap_stretch;
    int                             fault_count;

    session_table_with_aging #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .account_id (account_id),
        .session_id (session_id),
        .now_ms     (now_ms),
        .done       (done),
        .was_present(was_present),
        .removed    (removed),
        .table_full (table_full),
        .swept_count(swept_count),
        .live_count (live_count),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #1_500_000;
        $display("tb_session_table_with_aging NOT OK");
        $finish;
    end

    function automatic int lookup_account(logic [sta_pkg::ACCT_W-1:0] acct);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (tbl_valid[i] && tbl_account[i] == acct)
                return i;
        end
        return -1;
    endfunction

    // Apply one action to the shadow table and return the result it yields
    function automatic outcome_t step_session_table(logic [1:0] act,
                                                    logic [sta_pkg::ACCT_W-1:0] acct,
                                                    logic [sta_pkg::SID_W-1:0] sid,
                                                    logic [sta_pkg::TIME_W-1:0] stamp);
        outcome_t o;
        int       slot;
        o = '0;
        case (act)
            sta_pkg::ACT_PUT, sta_pkg::ACT_REFRESH:
            begin
                slot = lookup_account(acct);
                if (slot >= 0)
                    o.was_present = 1'b1;
                else
                begin
                    // new account takes the lowest free entry
                    for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
                    begin
                        if (!tbl_valid[i])
                            slot = i;
                    end
                    if (slot < 0)
                        o.table_full = 1'b1;
                    else
                    begin
                        tbl_valid[slot]   = 1'b1;
                        tbl_account[slot] = acct;
                        live_total++;
                    end
                end
                if (slot >= 0)
                begin
                    tbl_session[slot] = sid;
                    tbl_stamp[slot]   = stamp;
                end
            end
            sta_pkg::ACT_REMOVE:
            begin
                slot = lookup_account(acct);
                if (slot >= 0 && tbl_session[slot] == sid)
                begin
                    tbl_valid[slot] = 1'b0;
                    live_total--;
                    o.removed = 1'b1;
                end
            end
            default:
            begin
                // drop entries older than grace; future stamps stay
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (tbl_valid[i] && stamp > tbl_stamp[i] &&
                        (stamp - tbl_stamp[i]) > {32'd0, grace_cfg})
                    begin
                        tbl_valid[i] = 1'b0;
                        live_total--;
                        o.swept_count++;
                    end
                end
            end
        endcase
        o.live_count = live_total[sta_pkg::COUNT_W-1:0];
        return o;
    endfunction

    function automatic void check_field(string name, logic [sta_pkg::COUNT_W-1:0] want,
                                        logic [sta_pkg::COUNT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endfunction

    // Compare every result strobe against the oldest pending expectation
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result strobe with no transaction pending");
                fault_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("was_present", sta_pkg::COUNT_W'(want.was_present),
                            sta_pkg::COUNT_W'(was_present));
                check_field("removed", sta_pkg::COUNT_W'(want.removed),
                            sta_pkg::COUNT_W'(removed));
                check_field("table_full", sta_pkg::COUNT_W'(want.table_full),
                            sta_pkg::COUNT_W'(table_full));
                check_field("swept_count", want.swept_count, swept_count);
                check_field("live_count", want.live_count, live_count);
            end
        end
    end

    // Send one transaction, then record what it should return
    task automatic issue_action(logic [1:0] act, logic [sta_pkg::ACCT_W-1:0] acct,
                                logic [sta_pkg::SID_W-1:0] sid,
                                logic [sta_pkg::TIME_W-1:0] stamp,
                                bit typed, outcome_t typed_out);
        int       gap;
        outcome_t predicted;
        if ($urandom_range(0, 39) == 0)
            no_gap_stretch = !no_gap_stretch;
        gap = no_gap_stretch ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            // half the gaps start once the block has gone idle
            if ($urandom_range(0, 1) == 1)
            begin
                do
                    @(posedge clk);
                while (busy);
            end
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        action     <= act;
        account_id <= acct;
        session_id <= sid;
        now_ms     <= stamp;
        do
            @(posedge clk);
        while (busy);
        predicted = step_session_table(act, acct, sid, stamp);
        pending_outcomes.push_back(typed ? typed_out : predicted);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_outcomes.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Write grace over the register port and read it back
    task automatic program_grace(logic [sta_pkg::GRACE_W-1:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sta_pkg::REG_GRACE, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== value)
        begin
            $error("grace_ms readback: expected %0d, got %0d", value, prdata);
            fault_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        grace_cfg = value;
    endtask

    task automatic draw_random_item(output logic [1:0] act,
                                    output logic [sta_pkg::ACCT_W-1:0] acct,
                                    output logic [sta_pkg::SID_W-1:0] sid,
                                    output logic [sta_pkg::TIME_W-1:0] stamp);
        int pick;
        int slot;
        pick = $urandom_range(0, 99);
        act  = pick < 35 ? sta_pkg::ACT_PUT :
               pick < 55 ? sta_pkg::ACT_REMOVE :
               pick < 85 ? sta_pkg::ACT_REFRESH : sta_pkg::ACT_SWEEP;
        acct = ($urandom_range(0, 99) < 85) ? acct_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : $urandom;
        sid  = {$urandom, $urandom};
        // aim most removes at a live entry, usually with its own session id
        if (act == sta_pkg::ACT_REMOVE && $urandom_range(0, 9) < 6)
        begin
            slot = $urandom_range(0, TABLE_ENTRIES - 1);
            for (int k = 0; k < TABLE_ENTRIES && !tbl_valid[slot]; k++)
                slot = (slot + 1) % TABLE_ENTRIES;
            if (tbl_valid[slot])
            begin
                acct = tbl_account[slot];
                if ($urandom_range(0, 4) != 0)
                    sid = tbl_session[slot];
            end
        end
        // advance the clock, with rare jumps long enough to expire the widest grace
        pick = $urandom_range(0, 99);
        if (pick < 90)
            clock_ms += $urandom_range(0, 4000);
        else if (pick < 97)
            clock_ms += $urandom_range(0, 60000);
        else
            clock_ms += {31'd0, $urandom, 1'b0};
        pick = $urandom_range(0, 99);
        if (pick < 88)
            stamp = clock_ms;
        else if (pick < 96)
            stamp = clock_ms - $urandom_range(0, 5000);
        else
            stamp = {$urandom, $urandom};
    endtask

    task automatic run_random(int count);
        logic [1:0]                 act;
        logic [sta_pkg::ACCT_W-1:0] acct;
        logic [sta_pkg::SID_W-1:0]  sid;
        logic [sta_pkg::TIME_W-1:0] stamp;
        for (int n = 0; n < count; n++)
        begin
            draw_random_item(act, acct, sid, stamp);
            issue_action(act, acct, sid, stamp, 1'b0, '0);
        end
    endtask

    // Insert fresh accounts past capacity, then age the whole table out
    task automatic fill_until_full();
        for (int k = 0; k < TABLE_ENTRIES + 4; k++)
        begin
            clock_ms += $urandom_range(0, 50);
            issue_action($urandom_range(0, 1) ? sta_pkg::ACT_PUT : sta_pkg::ACT_REFRESH,
                         $urandom, {$urandom, $urandom}, clock_ms, 1'b0, '0);
        end
        clock_ms += {32'd0, grace_cfg} + 64'd1 + $urandom_range(0, 100);
        issue_action(sta_pkg::ACT_SWEEP, $urandom, {$urandom, $urandom}, clock_ms,
                     1'b0, '0);
    endtask

    function automatic void add_directed(logic [1:0] act, logic [sta_pkg::ACCT_W-1:0] acct,
                                         logic [sta_pkg::SID_W-1:0] sid,
                                         logic [sta_pkg::TIME_W-1:0] stamp,
                                         bit typed, outcome_t want);
        stim_row_t r;
        r.action  = act;
        r.account = acct;
        r.session = sid;
        r.stamp   = stamp;
        r.typed   = typed;
        r.want    = want;
        directed_rows.push_back(r);
    endfunction

    initial
    begin
        logic [sta_pkg::GRACE_W-1:0] phase_grace [5];
        stim_row_t                   r;

        fault_count    = 0;
        no_gap_stretch = 1'b0;
        live_total     = 0;
        grace_cfg      = sta_pkg::GRACE_RESET;
        clock_ms       = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            tbl_valid[i] = 1'b0;
        acct_pool[0] = '0;
        acct_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            acct_pool[i] = $urandom;

        // Hold reset, then let the clearing pass finish
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (!busy);
        do
            @(posedge clk);
        while (busy);

        // Directed part at the reset grace of 30000
        add_directed(sta_pkg::ACT_SWEEP, '0, '0, '0, 1'b1,
                     '{1'b0, 1'b0, 1'b0, 7'd0, 7'd0});
        add_directed(sta_pkg::ACT_REMOVE, 32'd5, '0, '0, 1'b1,
                     '{1'b0, 1'b0, 1'b0, 7'd0, 7'd0});
        add_directed(sta_pkg::ACT_PUT, '0, '0, '0, 1'b1,
                     '{1'b0, 1'b0, 1'b0, 7'd0, 7'd1});
        add_directed(sta_pkg::ACT_PUT, '1, '1, '1, 1'b1,
                     '{1'b0, 1'b0, 1'b0, 7'd0, 7'd2});
        add_directed(sta_pkg::ACT_PUT, '0, 64'h123, 64'd100, 1'b1,
                     '{1'b1, 1'b0, 1'b0, 7'd0, 7'd2});
        add_directed(sta_pkg::ACT_REFRESH, 32'd7, 64'hA5A5_A5A5_A5A5_A5A5, 64'd50, 1'b1,
                     '{1'b0, 1'b0, 1'b0, 7'd0, 7'd3});
        add_directed(sta_pkg::ACT_REFRESH, 32'd7, 64'h5A5A_5A5A_5A5A_5A5A, 64'd60,
                     1'b0, '0);
        add_directed(sta_pkg::ACT_REMOVE, '0, 64'h124, '0, 1'b0, '0);
        add_directed(sta_pkg::ACT_REMOVE, '0, 64'h123, '0, 1'b0, '0);
        add_directed(sta_pkg::ACT_REMOVE, '0, 64'h123, '0, 1'b0, '0);
        // age exactly equal to grace is kept, one more is dropped
        add_directed(sta_pkg::ACT_SWEEP, '0, '0, 64'd30060, 1'b0, '0);
        add_directed(sta_pkg::ACT_SWEEP, '0, '0, 64'd30061, 1'b0, '0);
        add_directed(sta_pkg::ACT_REFRESH, 32'h8000_0000, 64'h8000_0000_0000_0000,
                     64'h8000_0000_0000_0000, 1'b0, '0);
        add_directed(sta_pkg::ACT_SWEEP, '1, '1, '1, 1'b0, '0);
        add_directed(sta_pkg::ACT_SWEEP, '0, '0, '0, 1'b0, '0);
        add_directed(sta_pkg::ACT_REMOVE, '1, '1, '0, 1'b0, '0);
        add_directed(sta_pkg::ACT_PUT, 32'h5555_5555, 64'h5555_5555_5555_5555,
                     64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0);
        add_directed(sta_pkg::ACT_REFRESH, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA,
                     64'h5555_5555_5555_5555, 1'b0, '0);
        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            issue_action(r.action, r.account, r.session, r.stamp, r.typed, r.want);
        end

        // Random phases over several grace settings, extremes included
        phase_grace[0] = '0;
        phase_grace[1] = '1;
        phase_grace[2] = 32'd1000;
        phase_grace[3] = $urandom_range(1, 200000);
        phase_grace[4] = 32'd1;
        for (int p = 0; p < 5; p++)
        begin
            program_grace(phase_grace[p]);
            clock_ms = (p % 2 == 1) ? {$urandom, $urandom} : '0;
            run_random(PHASE_ITEMS / 2);
            fill_until_full();
            run_random(PHASE_ITEMS / 2);
        end

        // Drain, then watch for stray strobes
        wait_idle();
        repeat (TABLE_ENTRIES + 8) @(posedge clk);
        if (fault_count == 0)
            $display("tb_session_table_with_aging OK");
        else
            $display("tb_session_table_with_aging NOT OK");
        $finish;
    end

endmodule
